FILE: sv/mlno_pkg.sv
// mlno_pkg: shared types, constants and helpers of the legato note processor
// used by mlno_ctrl, mlno_dp and midi_legato_note_overlap_core; depends on nothing
`default_nettype none

package mlno_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);

   localparam int NOTE_W  = 7;
   localparam int VEL_W   = 7;
   localparam int TIME_W  = 16;
   localparam int CLOCK_W = 32;
   localparam int CSR_W   = 16;
   localparam int ADDR_W  = 2;
   localparam int OP_W    = 2;

   localparam logic [OP_W-1:0] OP_NOTE  = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
   localparam logic [OP_W-1:0] OP_CUT   = 2'd3;

   localparam logic [ADDR_W-1:0] CSR_DEFAULT_VELOCITY = 2'd0;
   localparam logic [ADDR_W-1:0] CSR_NOTE_DURATION    = 2'd1;
   localparam logic [ADDR_W-1:0] CSR_OVERLAP_TIME     = 2'd2;

   localparam logic [VEL_W-1:0]  RESET_VELOCITY = 7'd64;
   localparam logic [TIME_W-1:0] RESET_DURATION = 16'd1000;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;             // latch note and velocity of an accepted word
      logic rd_scan;          // memory read address: scan pointer, else oldest
      logic release_oldest;   // drop oldest entry, note-off unless cancelled
      logic release_sounding; // immediate note-off of the sounding note
      logic insert;           // push sounding note into the ring
      logic scan_init;        // scan pointer from oldest
      logic scan_next;
      logic cancel;           // clear pitch at the scan pointer
      logic cancel_emit;      // and send the note-off of the new pitch
      logic note_on;
      logic cut;              // cut the sounding note
      logic stop;             // clear sounding note and countdown regardless
      logic tick;
      logic dur;              // run the duration countdown
      logic finish;           // flush the held word out as the last one
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic emit_ok;
      logic sounding_nz;
      logic note_nz;
      logic vel_zero;
      logic note_is_sounding;
      logic overlap_nz;
      logic full;
      logic empty;
      logic scan_end;
      logic pitch_match;
      logic expired;
      logic hold_valid;
   } dp_status_type;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

endpackage

`default_nettype wire

FILE: sv/mlno_ctrl.sv
// mlno_ctrl: sequencer of the legato note processor, one word at a time
// depends on mlno_pkg; drives mlno_dp through ctrl_cmd_type, reads dp_status_type
`default_nettype none

module mlno_ctrl (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire  [mlno_pkg::OP_W-1:0]   req_op,
   input  mlno_pkg::dp_status_type     st,
   output mlno_pkg::ctrl_cmd_type      cmd
);
   import mlno_pkg::*;

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_NOTE      = 5'd1;
   localparam logic [4:0] S_FULL_RD   = 5'd2;
   localparam logic [4:0] S_FULL_REL  = 5'd3;
   localparam logic [4:0] S_INSERT    = 5'd4;
   localparam logic [4:0] S_REL_SOUND = 5'd5;
   localparam logic [4:0] S_SCAN_INIT = 5'd6;
   localparam logic [4:0] S_SCAN_RD   = 5'd7;
   localparam logic [4:0] S_SCAN_CHK  = 5'd8;
   localparam logic [4:0] S_NOTE_ON   = 5'd9;
   localparam logic [4:0] S_CUT       = 5'd10;
   localparam logic [4:0] S_TICK      = 5'd11;
   localparam logic [4:0] S_TICK_CHK  = 5'd12;
   localparam logic [4:0] S_DUR       = 5'd13;
   localparam logic [4:0] S_FL_RD     = 5'd14;
   localparam logic [4:0] S_FL_REL    = 5'd15;
   localparam logic [4:0] S_FL_CUR    = 5'd16;
   localparam logic [4:0] S_FIN       = 5'd17;

   logic [4:0] state_ff, state_in;
   logic       scan_off_ff, scan_off_in;
   logic       accept_w;

   assign req_tready = (state_ff == S_IDLE);
   assign accept_w   = req_tvalid && req_tready;

   always_comb begin
      state_in    = state_ff;
      scan_off_in = scan_off_ff;
      cmd         = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept_w) begin
               cmd.load = 1'b1;
               case (req_op)
                  OP_NOTE:  state_in = S_NOTE;
                  OP_TICK:  state_in = S_TICK;
                  OP_FLUSH: state_in = S_FL_RD;
                  OP_CUT:   state_in = S_CUT;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_NOTE: begin
            if (st.vel_zero) begin
               scan_off_in = 1'b1;
               if (st.sounding_nz && st.note_is_sounding) begin
                  state_in = S_SCAN_INIT;
               end else begin
                  state_in = S_FIN;
               end
            end else begin
               scan_off_in = 1'b0;
               if (st.sounding_nz) begin
                  if (!st.overlap_nz) begin
                     state_in = S_REL_SOUND;
                  end else if (st.full) begin
                     state_in = S_FULL_RD;
                  end else begin
                     state_in = S_INSERT;
                  end
               end else if (st.note_nz) begin
                  state_in = S_SCAN_INIT;
               end else begin
                  state_in = S_NOTE_ON;
               end
            end
         end
         S_FULL_RD: begin
            state_in = S_FULL_REL;
         end
         S_FULL_REL: begin
            if (st.emit_ok) begin
               cmd.release_oldest = 1'b1;
               state_in           = S_INSERT;
            end
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = st.note_nz ? S_SCAN_INIT : S_NOTE_ON;
         end
         S_REL_SOUND: begin
            if (st.emit_ok) begin
               cmd.release_sounding = 1'b1;
               state_in             = st.note_nz ? S_SCAN_INIT : S_NOTE_ON;
            end
         end
         S_SCAN_INIT: begin
            cmd.scan_init = 1'b1;
            state_in      = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            cmd.rd_scan = 1'b1;
            if (st.scan_end) begin
               state_in = scan_off_ff ? S_CUT : S_NOTE_ON;
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (!st.pitch_match) begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end else if (scan_off_ff) begin
               cmd.cancel = 1'b1;
               state_in   = S_CUT;
            end else if (st.emit_ok) begin
               cmd.cancel      = 1'b1;
               cmd.cancel_emit = 1'b1;
               state_in        = S_NOTE_ON;
            end
         end
         S_NOTE_ON: begin
            if (st.emit_ok) begin
               cmd.note_on = 1'b1;
               state_in    = S_FIN;
            end
         end
         S_CUT: begin
            if (st.emit_ok) begin
               cmd.cut  = 1'b1;
               state_in = S_FIN;
            end
         end
         S_TICK: begin
            cmd.tick = 1'b1;
            state_in = st.empty ? S_DUR : S_TICK_CHK;
         end
         S_TICK_CHK: begin
            if (!st.expired) begin
               state_in = S_DUR;
            end else if (st.emit_ok) begin
               cmd.release_oldest = 1'b1;
               state_in           = S_DUR;
            end
         end
         S_DUR: begin
            if (st.emit_ok) begin
               cmd.dur  = 1'b1;
               state_in = S_FIN;
            end
         end
         S_FL_RD: begin
            state_in = st.empty ? S_FL_CUR : S_FL_REL;
         end
         S_FL_REL: begin
            if (st.emit_ok) begin
               cmd.release_oldest = 1'b1;
               state_in           = S_FL_RD;
            end
         end
         S_FL_CUR: begin
            if (st.emit_ok) begin
               cmd.cut  = 1'b1;
               cmd.stop = 1'b1;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (st.emit_ok) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         scan_off_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_off_ff <= scan_off_in;
      end
   end

`ifndef SYNTHESIS
   // the ring never takes an entry while it is full
   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !st.full) else $error("insert into full ring");

   // a word is only taken with nothing left in the hold stage
   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      accept_w |-> !st.hold_valid) else $error("word accepted with held result");
`endif

endmodule

`default_nettype wire

FILE: sv/mlno_dp.sv
// mlno_dp: datapath of the legato note processor: settings, ring of pending
// note-offs, sounding note, countdown, hold stage and output register; uses mlno_pkg
`default_nettype none

module mlno_dp (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           csr_we,
   input  wire  [mlno_pkg::ADDR_W-1:0]   csr_addr,
   input  wire  [mlno_pkg::CSR_W-1:0]    csr_wdata,
   input  wire  [mlno_pkg::NOTE_W-1:0]   req_note,
   input  wire  [mlno_pkg::VEL_W-1:0]    req_velocity,
   input  wire                           req_use_default,
   input  mlno_pkg::ctrl_cmd_type        cmd,
   output mlno_pkg::dp_status_type       st,
   input  wire                           rsp_tready,
   output logic                          rsp_tvalid,
   output logic [mlno_pkg::NOTE_W-1:0]   rsp_note,
   output logic [mlno_pkg::VEL_W-1:0]    rsp_velocity,
   output logic                          rsp_last
);
   import mlno_pkg::*;

   // settings
   logic [VEL_W-1:0]  def_vel_ff;
   logic [TIME_W-1:0] duration_ff;
   logic [TIME_W-1:0] overlap_ff;

   // ring of pending note-offs
   logic [NOTE_W-1:0]  pitch_mem  [QUEUE_DEPTH];
   logic [CLOCK_W-1:0] expiry_mem [QUEUE_DEPTH];
   logic [NOTE_W-1:0]  rd_pitch_ff;
   logic [CLOCK_W-1:0] rd_expiry_ff;
   logic [PTR_W-1:0]   rd_addr_w;

   logic [PTR_W-1:0]   oldest_ff, oldest_in;
   logic [PTR_W-1:0]   insert_ff, insert_in;
   logic [PTR_W-1:0]   scan_ff, scan_in;
   logic [NOTE_W-1:0]  sounding_ff, sounding_in;
   logic [CLOCK_W-1:0] clock_ff, clock_in;
   logic [TIME_W-1:0]  left_ff, left_in;
   logic               running_ff, running_in;

   // latched word
   logic [NOTE_W-1:0] note_ff, note_in;
   logic [VEL_W-1:0]  vel_ff, vel_in;

   // hold stage and output register
   logic              hold_valid_ff, hold_valid_in;
   logic [NOTE_W-1:0] hold_note_ff, hold_note_in;
   logic [VEL_W-1:0]  hold_vel_ff, hold_vel_in;
   logic              out_valid_ff, out_valid_in;
   logic [NOTE_W-1:0] out_note_ff, out_note_in;
   logic [VEL_W-1:0]  out_vel_ff, out_vel_in;
   logic              out_last_ff, out_last_in;

   logic              out_free_w;
   logic              out_push_w;
   logic              emit_w;
   logic [NOTE_W-1:0] emit_note_w;
   logic [VEL_W-1:0]  emit_vel_w;
   logic              sounding_nz_w;
   logic              dur_cut_w;
   logic [CLOCK_W-1:0] age_w;

   assign sounding_nz_w = (sounding_ff != '0);
   assign out_free_w    = !out_valid_ff || rsp_tready;
   assign dur_cut_w     = cmd.dur && running_ff && (left_ff <= TIME_W'(1));
   assign age_w         = clock_ff - rd_expiry_ff;
   assign rd_addr_w     = cmd.rd_scan ? scan_ff : oldest_ff;

   assign st.emit_ok          = !hold_valid_ff || out_free_w;
   assign st.sounding_nz      = sounding_nz_w;
   assign st.note_nz          = (note_ff != '0);
   assign st.vel_zero         = (vel_ff == '0);
   assign st.note_is_sounding = (note_ff == sounding_ff);
   assign st.overlap_nz       = (overlap_ff != '0);
   assign st.full             = (ring_next(insert_ff) == oldest_ff);
   assign st.empty            = (oldest_ff == insert_ff);
   assign st.scan_end         = (scan_ff == insert_ff);
   assign st.pitch_match      = (rd_pitch_ff == note_ff);
   assign st.expired          = !age_w[CLOCK_W-1];
   assign st.hold_valid       = hold_valid_ff;

   // one note-on or note-off per command at most
   always_comb begin
      emit_w      = 1'b0;
      emit_note_w = sounding_ff;
      emit_vel_w  = '0;
      if (cmd.release_oldest && (rd_pitch_ff != '0)) begin
         emit_w      = 1'b1;
         emit_note_w = rd_pitch_ff;
      end
      if (cmd.release_sounding) begin
         emit_w = 1'b1;
      end
      if (cmd.cancel && cmd.cancel_emit) begin
         emit_w      = 1'b1;
         emit_note_w = note_ff;
      end
      if (cmd.note_on) begin
         emit_w      = 1'b1;
         emit_note_w = note_ff;
         emit_vel_w  = vel_ff;
      end
      if ((cmd.cut || dur_cut_w) && sounding_nz_w) begin
         emit_w = 1'b1;
      end
   end

   // held word goes out when a newer one arrives (not last) or at finish (last)
   assign out_push_w = hold_valid_ff && (emit_w || cmd.finish);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_note_in  = hold_note_ff;
      hold_vel_in   = hold_vel_ff;
      if (emit_w) begin
         hold_valid_in = 1'b1;
         hold_note_in  = emit_note_w;
         hold_vel_in   = emit_vel_w;
      end else if (cmd.finish) begin
         hold_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_note_in  = out_note_ff;
      out_vel_in   = out_vel_ff;
      out_last_in  = out_last_ff;
      if (out_push_w) begin
         out_valid_in = 1'b1;
         out_note_in  = hold_note_ff;
         out_vel_in   = hold_vel_ff;
         out_last_in  = cmd.finish;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      note_in     = note_ff;
      vel_in      = vel_ff;
      oldest_in   = oldest_ff;
      insert_in   = insert_ff;
      scan_in     = scan_ff;
      sounding_in = sounding_ff;
      clock_in    = clock_ff;
      left_in     = left_ff;
      running_in  = running_ff;
      if (cmd.load) begin
         note_in = req_note;
         vel_in  = req_use_default ? def_vel_ff : req_velocity;
      end
      if (cmd.release_oldest) begin
         oldest_in = ring_next(oldest_ff);
      end
      if (cmd.insert) begin
         insert_in = ring_next(insert_ff);
      end
      if (cmd.scan_init) begin
         scan_in = oldest_ff;
      end else if (cmd.scan_next) begin
         scan_in = ring_next(scan_ff);
      end
      if (cmd.note_on) begin
         sounding_in = note_ff;
         left_in     = duration_ff;
         running_in  = 1'b1;
      end
      if ((cmd.cut && sounding_nz_w) || cmd.stop) begin
         sounding_in = '0;
         running_in  = 1'b0;
      end
      if (cmd.tick) begin
         clock_in = clock_ff + 1'b1;
      end
      if (cmd.dur && running_ff) begin
         if (dur_cut_w) begin
            left_in     = '0;
            sounding_in = '0;
            running_in  = 1'b0;
         end else begin
            left_in = left_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         def_vel_ff    <= RESET_VELOCITY;
         duration_ff   <= RESET_DURATION;
         overlap_ff    <= '0;
         oldest_ff     <= '0;
         insert_ff     <= '0;
         sounding_ff   <= '0;
         clock_ff      <= '0;
         left_ff       <= '0;
         running_ff    <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_DEFAULT_VELOCITY: def_vel_ff  <= csr_wdata[VEL_W-1:0];
               CSR_NOTE_DURATION:    duration_ff <= csr_wdata[TIME_W-1:0];
               CSR_OVERLAP_TIME:     overlap_ff  <= csr_wdata[TIME_W-1:0];
               default: begin
               end
            endcase
         end
         oldest_ff     <= oldest_in;
         insert_ff     <= insert_in;
         sounding_ff   <= sounding_in;
         clock_ff      <= clock_in;
         left_ff       <= left_in;
         running_ff    <= running_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      note_ff      <= note_in;
      vel_ff       <= vel_in;
      scan_ff      <= scan_in;
      hold_note_ff <= hold_note_in;
      hold_vel_ff  <= hold_vel_in;
      out_note_ff  <= out_note_in;
      out_vel_ff   <= out_vel_in;
      out_last_ff  <= out_last_in;
   end

   // pending note-off memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         pitch_mem[insert_ff]  <= sounding_ff;
         expiry_mem[insert_ff] <= clock_ff + CLOCK_W'(overlap_ff);
      end else if (cmd.cancel) begin
         pitch_mem[scan_ff] <= '0;
      end
      rd_pitch_ff  <= pitch_mem[rd_addr_w];
      rd_expiry_ff <= expiry_mem[rd_addr_w];
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_note     = out_note_ff;
   assign rsp_velocity = out_vel_ff;
   assign rsp_last     = out_last_ff;

`ifndef SYNTHESIS
   // the hold stage never spills into a busy output register
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      out_push_w |-> out_free_w) else $error("result overwritten in output register");

   // a note-on leaves its pitch sounding with the countdown running
   a_note_on: assert property (@(posedge clock) disable iff (reset)
      cmd.note_on |=> (sounding_ff == $past(note_ff)) && running_ff)
      else $error("note-on did not take effect");

   // an insert always leaves a non-empty ring
   a_insert_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> (oldest_ff != insert_ff)) else $error("ring empty after insert");

   // finishing empties the hold stage
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !hold_valid_ff) else $error("hold stage not empty after finish");
`endif

endmodule

`default_nettype wire

FILE: sv/midi_legato_note_overlap_core.sv
// midi_legato_note_overlap_core: top level of the legato note processor
// instantiates mlno_ctrl and mlno_dp; uses mlno_pkg
//
// req channel: one word per event; req_tuser carries op (note event, tick,
// flush, cut) and the use-default-velocity flag, req_tdata note and velocity.
// rsp channel: note-on / note-off words; rsp_tlast marks the final word an
// event produces. An event that produces nothing gives no rsp word at all.
// csr port: plain writes of default velocity, note duration and overlap time,
// to be made only while the block is idle; the block itself does not enforce it.
// Events are handled one at a time by the sequencer. A note event may release
// the sounding note or insert it into the ring (releasing the oldest entry
// first when the ring is full) and may search the pending entries for its pitch;
// a tick releases the oldest entry once it has expired, and a flush releases
// every queued entry. The ring holds at most 31 pending entries, and an event
// that searches or flushes it takes longer the more entries are pending, since
// the pending-note memory has a single read port, visited one entry per step.
// Results leave through a hold stage and an output register, so the next
// event is taken while the final word of the previous one waits on rsp_tready.
// A stalled receiver simply holds the sequencer in place; nothing is dropped.
// Synchronous reset empties the ring, clears the sounding note and clock and
// loads the registers with velocity 64, duration 1000, overlap 0.
`default_nettype none

module midi_legato_note_overlap_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire  [1:0]  csr_addr,
   input  wire  [15:0] csr_wdata,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [6:0] note, [13:7] velocity, [15:14] zero
   input  wire  [2:0]  req_tuser,   // [1:0] op, [2] use_default_velocity
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // [6:0] out_note, [13:7] out_velocity, [15:14] zero
   output logic        rsp_tlast
);
   import mlno_pkg::*;

   ctrl_cmd_type      cmd;
   dp_status_type     st;
   logic [NOTE_W-1:0] rsp_note;
   logic [VEL_W-1:0]  rsp_velocity;

   mlno_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser[OP_W-1:0]),
      .st         (st),
      .cmd        (cmd)
   );

   mlno_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .req_note        (req_tdata[NOTE_W-1:0]),
      .req_velocity    (req_tdata[NOTE_W+VEL_W-1:NOTE_W]),
      .req_use_default (req_tuser[OP_W]),
      .cmd             (cmd),
      .st              (st),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_note        (rsp_note),
      .rsp_velocity    (rsp_velocity),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_velocity, rsp_note};

endmodule

`default_nettype wire
